/* hw/rtl/cdf_pkg.sv */
// ============================================================================
// cdf_pkg: shared types and constants of the sync-header frame parser
// Holds the status codes, configuration register indexes, RAM request and
// result structures, and the CRC-16/CCITT-FALSE byte update.
// ============================================================================
package cdf_pkg;

    localparam int STORE_DEPTH     = 256;
    localparam int STORE_AW        = 8;
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int CFG_IDX_W       = 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [8:0]  PLEN_MAX = 9'h1FF;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_CRC_ERR = 2'd2,
        ST_LEN_ERR = 2'd3
    } status_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  packet_type;
        logic [8:0]  payload_length;
        logic        rd_hit;
        logic [31:0] good_count;
        logic [31:0] fault_count;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/cdf_ram.sv */
// ============================================================================
// cdf_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module cdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cdf_parser.sv */
// ============================================================================
// cdf_parser: frame state machine, CRC accumulation and packet counters
// Consumes one beat per accept, issues payload buffer writes and reads,
// and registers the result of that beat for the output stage.
// ============================================================================
module cdf_parser #(
    parameter int MAX_PAYLOAD = cdf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           accept,
    input  logic                           action,
    input  logic [7:0]                     rx_byte,
    input  logic [7:0]                     read_index,
    output cdf_pkg::ram_req_t              ram_req,
    output cdf_pkg::result_t               res
);

    localparam int LEN_W = (MAX_PAYLOAD < 2) ? 1 : $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    phase_t            phase_reg,     phase_next;
    logic [7:0]        sync1_reg,     sync1_next;
    logic [7:0]        sync2_reg,     sync2_next;
    logic [7:0]        type_reg,      type_next;
    logic [7:0]        len_lo_reg,    len_lo_next;
    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]  fill_reg,      fill_next;
    logic [15:0]       crc_reg,       crc_next;
    logic [7:0]        crc_lo_reg,    crc_lo_next;
    logic [31:0]       good_reg,      good_next;
    logic [31:0]       err_reg,       err_next;
    logic [7:0]        last_type_reg, last_type_next;
    logic [LEN_W-1:0]  last_len_reg,  last_len_next;
    cdf_pkg::result_t  res_reg,       res_next;

    logic [15:0]       crc_upd;
    logic [15:0]       full_len;
    logic [15:0]       rx_crc;
    logic [LEN_W-1:0]  fill_inc;
    logic [15:0]       last_len_ext;
    cdf_pkg::status_t  status_v;
    logic              rd_hit_v;

    always_comb
    begin
        phase_next     = phase_reg;
        sync1_next     = sync1_reg;
        sync2_next     = sync2_reg;
        type_next      = type_reg;
        len_lo_next    = len_lo_reg;
        frame_len_next = frame_len_reg;
        fill_next      = fill_reg;
        crc_next       = crc_reg;
        crc_lo_next    = crc_lo_reg;
        good_next      = good_reg;
        err_next       = err_reg;
        last_type_next = last_type_reg;
        last_len_next  = last_len_reg;
        status_v       = cdf_pkg::ST_BUSY;
        rd_hit_v       = 1'b0;

        crc_upd  = cdf_pkg::crc_feed(crc_reg, rx_byte);
        full_len = {rx_byte, len_lo_reg};
        rx_crc   = {rx_byte, crc_lo_reg};
        fill_inc = fill_reg + 1'b1;

        ram_req       = '0;
        ram_req.raddr = cdf_pkg::STORE_AW'(read_index);
        ram_req.waddr = cdf_pkg::STORE_AW'(fill_reg);
        ram_req.wdata = rx_byte;

        if (cfg_we)
        begin
            case (cfg_index)
                cdf_pkg::REG_SYNC_FIRST:  sync1_next = cfg_wdata;
                cdf_pkg::REG_SYNC_SECOND: sync2_next = cfg_wdata;
                default:                  sync1_next = sync1_reg;
            endcase
        end

        if (accept && action == cdf_pkg::ACT_READ)
        begin
            ram_req.re = 1'b1;
            rd_hit_v   = {8'h00, read_index} < 16'(last_len_reg);
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_byte == sync1_reg)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == sync2_reg) ? PH_TYPE : PH_SYNC1;
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    crc_next   = cdf_pkg::crc_feed(cdf_pkg::CRC_INIT, rx_byte);
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_lo_next = rx_byte;
                    crc_next    = crc_upd;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    crc_next = crc_upd;
                    if (full_len > MAX_LEN)
                    begin
                        phase_next = PH_SYNC1;
                        err_next   = err_reg + 32'd1;
                        status_v   = cdf_pkg::ST_LEN_ERR;
                    end
                    else
                    begin
                        frame_len_next = LEN_W'(full_len);
                        fill_next      = '0;
                        phase_next     = (full_len != 16'h0000) ? PH_DATA : PH_CRC_LO;
                    end
                end
                PH_DATA:
                begin
                    ram_req.we = 16'(fill_reg) < 16'(cdf_pkg::STORE_DEPTH);
                    crc_next   = crc_upd;
                    fill_next  = fill_inc;
                    if (fill_inc >= frame_len_reg)
                    begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    phase_next = PH_SYNC1;
                    if (rx_crc == crc_reg)
                    begin
                        last_type_next = type_reg;
                        last_len_next  = frame_len_reg;
                        good_next      = good_reg + 32'd1;
                        status_v       = cdf_pkg::ST_GOOD;
                    end
                    else
                    begin
                        err_next = err_reg + 32'd1;
                        status_v = cdf_pkg::ST_CRC_ERR;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end

        last_len_ext            = 16'(last_len_next);
        res_next.status         = status_v;
        res_next.packet_type    = last_type_next;
        res_next.payload_length = (last_len_ext > 16'(cdf_pkg::PLEN_MAX)) ?
                                  cdf_pkg::PLEN_MAX : last_len_ext[8:0];
        res_next.rd_hit         = rd_hit_v;
        res_next.good_count     = good_next;
        res_next.fault_count    = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            sync1_reg     <= cdf_pkg::SYNC_FIRST_RST;
            sync2_reg     <= cdf_pkg::SYNC_SECOND_RST;
            type_reg      <= '0;
            len_lo_reg    <= '0;
            frame_len_reg <= '0;
            fill_reg      <= '0;
            crc_reg       <= cdf_pkg::CRC_INIT;
            crc_lo_reg    <= '0;
            good_reg      <= '0;
            err_reg       <= '0;
            last_type_reg <= '0;
            last_len_reg  <= '0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sync1_reg     <= sync1_next;
            sync2_reg     <= sync2_next;
            type_reg      <= type_next;
            len_lo_reg    <= len_lo_next;
            frame_len_reg <= frame_len_next;
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            good_reg      <= good_next;
            err_reg       <= err_next;
            last_type_reg <= last_type_next;
            last_len_reg  <= last_len_next;
            if (accept)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign res = res_reg;

endmodule

/* hw/rtl/crc16_packet_deframer.sv */
// ============================================================================
// crc16_packet_deframer: sync-header, length and CRC-16 frame parser
// An accepted beat is registered in the parser result stage, then the output
// stage. Throughput is one beat per cycle unless the output stalls, set by the
// single payload RAM port pair. Reset clears the parser state, counters and
// both stage valid flags; the payload RAM is not cleared and needs no clearing.
// ============================================================================
module crc16_packet_deframer #(
    parameter int MAX_PAYLOAD = cdf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [7:0]                    rx_byte,
    input  logic [7:0]                    read_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [7:0]                    packet_type,
    output logic [8:0]                    payload_length,
    output logic [7:0]                    read_data,
    output logic [31:0]                   good_count,
    output logic [31:0]                   fault_count
);

    cdf_pkg::ram_req_t ram_req;
    cdf_pkg::result_t  res;
    cdf_pkg::result_t  out_reg,       out_next;
    logic [7:0]        rdata_out_reg, rdata_out_next;
    logic [7:0]        ram_rdata;
    logic              s1_valid_reg,  s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              s1_adv;
    logic              accept;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    cdf_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .action     (action),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .ram_req    (ram_req),
        .res        (res)
    );

    cdf_ram #(
        .WIDTH (8),
        .DEPTH (cdf_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
        out_next       = out_reg;
        rdata_out_next = rdata_out_reg;
        if (s1_adv)
        begin
            out_next       = res;
            rdata_out_next = res.rd_hit ? ram_rdata : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        rdata_out_reg <= rdata_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign packet_type    = out_reg.packet_type;
    assign payload_length = out_reg.payload_length;
    assign read_data      = rdata_out_reg;
    assign good_count     = out_reg.good_count;
    assign fault_count    = out_reg.fault_count;

endmodule

/* hw/rtl/cdf_checker.sv */
// ============================================================================
// cdf_checker: port-level checks of the frame parser
// Watches the handshakes and result beats of the top level over time.
// ============================================================================
module cdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [7:0]  packet_type,
    input logic [8:0]  payload_length,
    input logic [7:0]  read_data,
    input logic [31:0] good_count,
    input logic [31:0] fault_count
);

    // A stalled output beat keeps its whole payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_data)
            && $stable(packet_type) && $stable(payload_length)
            && $stable(good_count) && $stable(fault_count))
        else $error("stalled output beat changed");

    // The input side only stalls when a finished beat is held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output beat");

    // A beat that reports a frame outcome comes from a received byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'(cdf_pkg::ST_BUSY) |-> read_data == 8'h00)
        else $error("read data on a receive beat");

    // No output beat appears directly after reset.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output beat right after reset");

endmodule

bind crc16_packet_deframer cdf_checker u_cdf_checker (.*);
